// ===== rtl/core/bpb_pkg.sv =====
// Shared types and constants of the bit packet builder.
`default_nettype none

package bpb_pkg;

  // Payload widths of the two channels
  localparam int unsigned CMD_W   = 3;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned NBITS_W = 6;
  localparam int unsigned INDEX_W = 8;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 12;
  localparam int unsigned CHECK_W = 16;

  // Longest field in bits
  localparam logic [NBITS_W-1:0] MAX_FIELD_BITS = NBITS_W'(32);

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR     = 3'd0,
    CMD_ADD_BIG   = 3'd1,
    CMD_ADD_LITTLE = 3'd2,
    CMD_LRC       = 3'd3,
    CMD_FL_BIG    = 3'd4,
    CMD_FL_LITTLE = 3'd5,
    CMD_READ      = 3'd6
  } cmd_e;

  // Control from the sequencer to the bit insertion unit
  typedef struct packed {
    logic                 clear;   // zero pointer, flag and partial byte
    logic                 round;   // round pointer up to a byte boundary
    logic                 start;   // begin appending a field
    logic                 little;  // low byte first
    logic [VALUE_W-1:0]   value;
    logic [NBITS_W-1:0]   nbits;   // already limited to 32
  } ins_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/bpb_in_if.sv =====
// Command channel of the bit packet builder.
`default_nettype none

interface bpb_in_if import bpb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [VALUE_W-1:0] field_value;
  logic [NBITS_W-1:0] field_bits;
  logic [INDEX_W-1:0] byte_index;

  modport source (output valid, output command, output field_value, output field_bits,
                  output byte_index, input ready);
  modport sink   (input valid, input command, input field_value, input field_bits,
                  input byte_index, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bpb_out_if.sv =====
// Result channel of the bit packet builder.
`default_nettype none

interface bpb_out_if import bpb_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [BYTE_W-1:0]  read_byte;
  logic [LEN_W-1:0]   length_bits;
  logic [CHECK_W-1:0] check_value;
  logic               overflow;

  modport source (output valid, output read_byte, output length_bits, output check_value,
                  output overflow, input ready);
  modport sink   (input valid, input read_byte, input length_bits, input check_value,
                  input overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bpb_store.sv =====
// Packet byte store: one write port, one read port with registered data.
`default_nettype none

module bpb_store import bpb_pkg::*; #(
  parameter int unsigned PACKET_BYTES = 256,
  localparam int unsigned AW = $clog2(PACKET_BYTES)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [BYTE_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [BYTE_W-1:0] rdata_o
);

  logic [BYTE_W-1:0] mem_q [PACKET_BYTES];
  logic [BYTE_W-1:0] rdata_q;

  // Write one byte
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one byte, data valid next cycle
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/bpb_insert.sv =====
// Bit insertion unit: places up to one byte's worth of field bits per cycle.
`default_nettype none

module bpb_insert import bpb_pkg::*; #(
  parameter int unsigned PACKET_BYTES = 256,
  localparam int unsigned AW = $clog2(PACKET_BYTES),
  localparam int unsigned PW = $clog2(PACKET_BYTES * 8 + 1),
  localparam int unsigned CAP_BITS = PACKET_BYTES * 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ins_ctrl_t         ctrl_i,
  output logic              busy_o,
  output logic [PW-1:0]     ptr_o,
  output logic              ovf_o,
  output logic              we_o,
  output logic [AW-1:0]     waddr_o,
  output logic [BYTE_W-1:0] wdata_o
);

  logic [PW-1:0]      ptr_q, ptr_d;
  logic               ovf_q, ovf_d;
  logic               busy_q, busy_d;
  logic               little_q, little_d;
  logic [BYTE_W-1:0]  cur_q, cur_d;     // partial byte at the pointer
  logic [VALUE_W-1:0] val_q, val_d;     // bits not yet cut into segments
  logic [NBITS_W-1:0] rem_q, rem_d;     // bit count left in val_q
  logic [BYTE_W-1:0]  seg_q, seg_d;     // current segment, MSB aligned
  logic [3:0]         srem_q, srem_d;   // bits left in the segment

  logic [2:0]         off;
  logic [3:0]         free_bits;
  logic [3:0]         take;
  logic [3:0]         seg_len;
  logic [BYTE_W-1:0]  merged;
  logic               full;

  assign off       = ptr_q[2:0];
  assign free_bits = 4'd8 - {1'b0, off};
  assign take      = (srem_q < free_bits) ? srem_q : free_bits;
  assign seg_len   = (rem_q > NBITS_W'(8)) ? 4'd8 : rem_q[3:0];
  assign merged    = cur_q | (seg_q >> off);
  assign full      = (ptr_q == PW'(CAP_BITS));

  // Clear, round or start a field, then sequence segment loads and byte merges, dropping bits once full
  always_comb begin
    ptr_d    = ptr_q;
    ovf_d    = ovf_q;
    busy_d   = busy_q;
    little_d = little_q;
    cur_d    = cur_q;
    val_d    = val_q;
    rem_d    = rem_q;
    seg_d    = seg_q;
    srem_d   = srem_q;
    we_o     = 1'b0;
    waddr_o  = AW'(ptr_q >> 3);
    wdata_o  = merged;
    if (ctrl_i.clear) begin
      ptr_d  = '0;
      ovf_d  = 1'b0;
      cur_d  = '0;
      busy_d = 1'b0;
    end else if (ctrl_i.round) begin
      if (off != 3'd0) begin
        ptr_d = (ptr_q | PW'(7)) + PW'(1);
        cur_d = '0;
      end
    end else if (ctrl_i.start) begin
      little_d = ctrl_i.little;
      val_d    = ctrl_i.little ? ctrl_i.value
                               : (ctrl_i.value << (MAX_FIELD_BITS - ctrl_i.nbits));
      rem_d    = ctrl_i.nbits;
      srem_d   = '0;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (srem_q == 4'd0) begin
        if (rem_q == '0) begin
          busy_d = 1'b0;
        end else begin
          // Cut the next segment
          if (little_q) begin
            seg_d = BYTE_W'(val_q[7:0] << (4'd8 - seg_len));
            val_d = val_q >> 8;
          end else begin
            seg_d = val_q[31:24];
            val_d = val_q << 8;
          end
          rem_d  = rem_q - NBITS_W'(seg_len);
          srem_d = seg_len;
        end
      end else if (full) begin
        // Drop what is left
        ovf_d  = 1'b1;
        srem_d = '0;
        rem_d  = '0;
      end else begin
        // Merge into the byte at the pointer
        we_o   = 1'b1;
        seg_d  = BYTE_W'(seg_q << take);
        srem_d = srem_q - take;
        ptr_d  = ptr_q + PW'(take);
        cur_d  = (({1'b0, off} + take) == 4'd8) ? '0 : merged;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q    <= '0;
      ovf_q    <= 1'b0;
      busy_q   <= 1'b0;
      little_q <= 1'b0;
      cur_q    <= '0;
      rem_q    <= '0;
      srem_q   <= '0;
    end else begin
      ptr_q    <= ptr_d;
      ovf_q    <= ovf_d;
      busy_q   <= busy_d;
      little_q <= little_d;
      cur_q    <= cur_d;
      rem_q    <= rem_d;
      srem_q   <= srem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    seg_q <= seg_d;
  end

  assign busy_o = busy_q;
  assign ptr_o  = ptr_q;
  assign ovf_o  = ovf_q;

endmodule

`default_nettype wire

// ===== rtl/core/bpb_csum.sv =====
// Checksum walker: reads stored bytes one per cycle, bar fold bubbles, into LRC/Fletcher-16 sums.
`default_nettype none

module bpb_csum import bpb_pkg::*; #(
  parameter int unsigned PACKET_BYTES = 256,
  localparam int unsigned AW = $clog2(PACKET_BYTES),
  localparam int unsigned CW = $clog2(PACKET_BYTES + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [CW-1:0]      nbytes_i,
  output logic               rd_en_o,
  output logic [AW-1:0]      rd_addr_o,
  input  logic [BYTE_W-1:0]  rd_data_i,
  output logic               done_o,
  output logic [BYTE_W-1:0]  lrc_o,
  output logic [CHECK_W-1:0] fletcher_o
);

  localparam int unsigned FLETCHER_BLOCK = 21;
  localparam logic [4:0]  BLOCK_LAST     = 5'(FLETCHER_BLOCK - 1);
  localparam logic [15:0] SUM_INIT       = 16'h00ff;

  typedef enum logic [3:0] {
    CS_IDLE      = 4'b0001,
    CS_WALK      = 4'b0010,
    CS_FOLD_LAST = 4'b0100,
    CS_FOLD_END  = 4'b1000
  } cs_state_e;

  function automatic logic [15:0] fold16(input logic [15:0] x);
    return {8'h00, x[7:0]} + {8'h00, x[15:8]};
  endfunction

  cs_state_e   state_q, state_d;
  logic [CW-1:0] issue_q, issue_d;
  logic [CW-1:0] nbytes_q, nbytes_d;
  logic [4:0]  iblk_q, iblk_d;     // bytes issued in the current block
  logic [4:0]  cblk_q, cblk_d;     // bytes summed in the current block
  logic        hold_q, hold_d;     // bubble before a block fold
  logic        dv_q, dv_d;         // read data arrives this cycle
  logic        fold_q, fold_d;     // fold sums this cycle
  logic        done_q, done_d;
  logic [15:0] s1_q, s1_d;
  logic [15:0] s2_q, s2_d;
  logic [7:0]  x_q, x_d;
  logic [15:0] s1_add;
  logic        issue;

  assign s1_add = s1_q + {8'h00, rd_data_i};
  assign issue  = (state_q == CS_WALK) && !hold_q && (issue_q < nbytes_q);

  always_comb begin
    state_d  = state_q;
    issue_d  = issue_q;
    nbytes_d = nbytes_q;
    iblk_d   = iblk_q;
    cblk_d   = cblk_q;
    hold_d   = 1'b0;
    dv_d     = issue;
    fold_d   = 1'b0;
    done_d   = 1'b0;
    s1_d     = s1_q;
    s2_d     = s2_q;
    x_d      = x_q;
    unique case (state_q)
      CS_IDLE: begin
        if (start_i) begin
          issue_d  = '0;
          nbytes_d = nbytes_i;
          iblk_d   = '0;
          cblk_d   = '0;
          s1_d     = SUM_INIT;
          s2_d     = SUM_INIT;
          x_d      = '0;
          state_d  = CS_WALK;
        end
      end
      CS_WALK: begin
        // Issue side
        if (issue) begin
          issue_d = issue_q + CW'(1);
          if (iblk_q == BLOCK_LAST) begin
            iblk_d = '0;
            hold_d = 1'b1;
          end else begin
            iblk_d = iblk_q + 5'd1;
          end
        end
        // Sum side
        if (dv_q) begin
          x_d  = x_q ^ rd_data_i;
          s1_d = s1_add;
          s2_d = s2_q + s1_add;
          if (cblk_q == BLOCK_LAST) begin
            cblk_d = '0;
            fold_d = 1'b1;
          end else begin
            cblk_d = cblk_q + 5'd1;
          end
        end else if (fold_q) begin
          s1_d = fold16(s1_q);
          s2_d = fold16(s2_q);
        end
        if (!issue && (issue_q == nbytes_q) && !dv_q && !fold_q) begin
          state_d = CS_FOLD_LAST;
        end
      end
      CS_FOLD_LAST: begin
        // Close a partial last block
        if (cblk_q != 5'd0) begin
          s1_d = fold16(s1_q);
          s2_d = fold16(s2_q);
        end
        state_d = CS_FOLD_END;
      end
      CS_FOLD_END: begin
        s1_d    = fold16(s1_q);
        s2_d    = fold16(s2_q);
        done_d  = 1'b1;
        state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= CS_IDLE;
      issue_q <= '0;
      nbytes_q <= '0;
      iblk_q  <= '0;
      cblk_q  <= '0;
      hold_q  <= 1'b0;
      dv_q    <= 1'b0;
      fold_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      issue_q <= issue_d;
      nbytes_q <= nbytes_d;
      iblk_q  <= iblk_d;
      cblk_q  <= cblk_d;
      hold_q  <= hold_d;
      dv_q    <= dv_d;
      fold_q  <= fold_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    s2_q <= s2_d;
    x_q  <= x_d;
  end

  assign rd_en_o    = issue;
  assign rd_addr_o  = AW'(issue_q);
  assign done_o     = done_q;
  assign lrc_o      = x_q;
  assign fletcher_o = {s1_q[7:0], s2_q[7:0]};

endmodule

`default_nettype wire

// ===== rtl/core/bit_packet_builder_with_checksum_core.sv =====
// Bit packet builder with LRC / Fletcher-16 checksum: command sequencer and top level.
//
//   channel | dir | payload                                         | moves a word when
//   in_i    | in  | command, field_value, field_bits, byte_index    | valid & ready
//   out_o   | out | read_byte, length_bits, check_value, overflow   | valid & ready
//
// One command at a time; in_i.ready is high only in the idle state. A finished word waits in
// the output register; the next command holds in its last cycle until out_o takes that word.
// Read: no store read, and a zero byte, when the byte is at or above the pointer.
// Field append: segments of up to a byte, each merged into one or two store bytes.
// Checksum: round the pointer up, walk the N stored bytes with one store read each, then
// append the LRC or the Fletcher-16 result. Reset clears pointer, flags and state only.
`default_nettype none

module bit_packet_builder_with_checksum_core import bpb_pkg::*; #(
  parameter int unsigned PACKET_BYTES = 256
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  bpb_in_if.sink     in_i,
  bpb_out_if.source  out_o
);

  localparam int unsigned AW = $clog2(PACKET_BYTES);
  localparam int unsigned PW = $clog2(PACKET_BYTES * 8 + 1);
  localparam int unsigned CW = $clog2(PACKET_BYTES + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_APPEND = 6'b000010,
    S_ROUND  = 6'b000100,
    S_SUM    = 6'b001000,
    S_READ   = 6'b010000,
    S_DONE   = 6'b100000
  } state_e;

  state_e       state_q, state_d;
  cmd_e         cmd_q, cmd_d;
  cmd_e         cmd_in;
  logic [BYTE_W-1:0]  rd_q, rd_d;
  logic [CHECK_W-1:0] check_q, check_d;

  logic               out_valid_q, out_valid_d;
  logic [BYTE_W-1:0]  out_rd_q, out_rd_d;
  logic [LEN_W-1:0]   out_len_q, out_len_d;
  logic [CHECK_W-1:0] out_check_q, out_check_d;
  logic               out_ovf_q, out_ovf_d;

  ins_ctrl_t          ins_ctrl;
  logic               ins_busy;
  logic [PW-1:0]      ins_ptr;
  logic               ins_ovf;
  logic               st_we;
  logic [AW-1:0]      st_waddr;
  logic [BYTE_W-1:0]  st_wdata;
  logic               st_re;
  logic [AW-1:0]      st_raddr;
  logic [BYTE_W-1:0]  st_rdata;

  logic               cs_start;
  logic               cs_rd_en;
  logic [AW-1:0]      cs_rd_addr;
  logic               cs_done;
  logic [BYTE_W-1:0]  cs_lrc;
  logic [CHECK_W-1:0] cs_fletcher;

  logic               top_re;
  logic               accept;
  logic [NBITS_W-1:0] nbits_sat;
  logic               rd_hit;
  logic               out_free;

  assign cmd_in    = cmd_e'(in_i.command);
  assign accept    = in_i.valid && (state_q == S_IDLE);
  assign nbits_sat = (in_i.field_bits > MAX_FIELD_BITS) ? MAX_FIELD_BITS : in_i.field_bits;
  // Only bytes below the pointer hold data
  assign rd_hit    = ({24'h000000, in_i.byte_index} << 3) < 32'(ins_ptr);
  assign out_free  = !out_valid_q || out_o.ready;

  // Sequence one command
  always_comb begin
    state_d        = state_q;
    cmd_d          = cmd_q;
    rd_d           = rd_q;
    check_d        = check_q;
    ins_ctrl       = '0;
    cs_start       = 1'b0;
    top_re         = 1'b0;
    out_valid_d    = out_valid_q && !out_o.ready;
    out_rd_d       = out_rd_q;
    out_len_d      = out_len_q;
    out_check_d    = out_check_q;
    out_ovf_d      = out_ovf_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_in;
          rd_d    = '0;
          check_d = '0;
          ins_ctrl.value = in_i.field_value;
          ins_ctrl.nbits = nbits_sat;
          unique case (cmd_in) inside
            CMD_CLEAR: begin
              ins_ctrl.clear = 1'b1;
              state_d        = S_DONE;
            end
            CMD_ADD_BIG: begin
              ins_ctrl.start = 1'b1;
              state_d        = S_APPEND;
            end
            CMD_ADD_LITTLE: begin
              ins_ctrl.start  = 1'b1;
              ins_ctrl.little = 1'b1;
              state_d         = S_APPEND;
            end
            CMD_LRC, CMD_FL_BIG, CMD_FL_LITTLE: begin
              ins_ctrl.round = 1'b1;
              state_d        = S_ROUND;
            end
            CMD_READ: begin
              top_re  = rd_hit;
              state_d = rd_hit ? S_READ : S_DONE;
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_ROUND: begin
        cs_start = 1'b1;
        state_d  = S_SUM;
      end
      S_SUM: begin
        if (cs_done) begin
          ins_ctrl.start = 1'b1;
          if (cmd_q == CMD_LRC) begin
            check_d        = {8'h00, cs_lrc};
            ins_ctrl.value = VALUE_W'(cs_lrc);
            ins_ctrl.nbits = NBITS_W'(8);
          end else begin
            check_d         = cs_fletcher;
            ins_ctrl.value  = VALUE_W'(cs_fletcher);
            ins_ctrl.nbits  = NBITS_W'(16);
            ins_ctrl.little = (cmd_q == CMD_FL_LITTLE);
          end
          state_d = S_APPEND;
        end
      end
      S_APPEND: begin
        if (!ins_busy) begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        rd_d    = st_rdata;
        state_d = S_DONE;
      end
      S_DONE: begin
        // Hand the result to the output register
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rd_d    = rd_q;
          out_len_d   = LEN_W'(ins_ptr);
          out_check_d = check_q;
          out_ovf_d   = ins_ovf;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= CMD_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q        <= rd_d;
    check_q     <= check_d;
    out_rd_q    <= out_rd_d;
    out_len_q   <= out_len_d;
    out_check_q <= out_check_d;
    out_ovf_q   <= out_ovf_d;
  end

  // Share the store read port between readback and the checksum walk
  assign st_re    = top_re || cs_rd_en;
  assign st_raddr = cs_rd_en ? cs_rd_addr : AW'(in_i.byte_index);

  bpb_insert #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_insert (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ins_ctrl),
    .busy_o  (ins_busy),
    .ptr_o   (ins_ptr),
    .ovf_o   (ins_ovf),
    .we_o    (st_we),
    .waddr_o (st_waddr),
    .wdata_o (st_wdata)
  );

  bpb_csum #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_csum (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cs_start),
    .nbytes_i   (CW'(ins_ptr >> 3)),
    .rd_en_o    (cs_rd_en),
    .rd_addr_o  (cs_rd_addr),
    .rd_data_i  (st_rdata),
    .done_o     (cs_done),
    .lrc_o      (cs_lrc),
    .fletcher_o (cs_fletcher)
  );

  bpb_store #(
    .PACKET_BYTES (PACKET_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.read_byte   = out_rd_q;
  assign out_o.length_bits = out_len_q;
  assign out_o.check_value = out_check_q;
  assign out_o.overflow    = out_ovf_q;

endmodule

`default_nettype wire
